// ===== rtl/core/piecewise_linear_table_interpolator_core_assert.svh =====
// Assertion macros for the piecewise linear table interpolator core
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATOR_CORE_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PLTI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PLTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/plti_pkg.sv =====
// Shared types and constants of the piecewise linear table interpolator
`default_nettype none
package plti_pkg;

  localparam int KEY_W     = 16;
  localparam int VAL_W     = 16;
  localparam int IDX_W     = 7;
  localparam int SEG_W     = 7;
  localparam int STAT_W    = 3;
  localparam int CFG_W     = 8;
  localparam int PROD_W    = 32;
  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_MUL,
    ST_DIV
  } state_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_LOW   = 3'd1,
    STAT_HIGH  = 3'd2,
    STAT_FEW   = 3'd3,
    STAT_WRITE = 3'd4
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [KEY_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/plti_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module plti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/plti_div.sv =====
// Restoring divider, one quotient bit per cycle, 16-bit quotient
`default_nettype none
module plti_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire plti_pkg::div_req_t req,
  output plti_pkg::div_rsp_t      rsp
);
  import plti_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [KEY_W-1:0]    rem_r, rem_nxt;
  logic [VAL_W-1:0]    lo_r, lo_nxt;     // dividend low bits, then quotient
  logic [KEY_W-1:0]    dvs_r, dvs_nxt;
  logic [KEY_W:0]      trial;
  logic                ge;

  // Caller guarantees quotient fits in 16 bits, so the high half is below the divisor
  always_comb begin
    trial    = {rem_r, lo_r[VAL_W-1]};
    ge       = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = req.dividend[PROD_W-1:VAL_W];
      lo_nxt   = req.dividend[VAL_W-1:0];
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? KEY_W'(trial - {1'b0, dvs_r}) : trial[KEY_W-1:0];
      lo_nxt  = {lo_r[VAL_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = lo_r;

endmodule
`default_nettype wire

// ===== rtl/core/piecewise_linear_table_interpolator_core.sv =====
// Top level: loadable breakpoint table with segment scan and linear interpolation
// Writes and too-few-points queries finish from ST_IDLE; a key at or below the first
//   breakpoint ends in ST_FIRST; other queries scan one entry per cycle in ST_SCAN and,
//   on a match, do one 16x16 multiply in ST_MUL and the divide in ST_DIV. One transaction
//   in flight, busy high until the result is issued; the result strobe cannot be stalled.
// Reset (rst_n, synchronous): FSM, divider, out_valid, points_in_use cleared; RAM is not.
`default_nettype none
`include "piecewise_linear_table_interpolator_core_assert.svh"
module piecewise_linear_table_interpolator_core #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_opcode,
  input  wire logic [plti_pkg::IDX_W-1:0]    in_entry_index,
  input  wire logic [plti_pkg::KEY_W-1:0]    in_key_value,
  input  wire logic [plti_pkg::VAL_W-1:0]    in_table_value,
  // result channel, one-cycle strobe
  output logic                               out_valid,
  output logic      [plti_pkg::VAL_W-1:0]    out_result_value,
  output logic      [plti_pkg::SEG_W-1:0]    out_segment_index,
  output logic      [plti_pkg::STAT_W-1:0]   out_status,
  // points_in_use register write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [plti_pkg::CFG_W-1:0]    cfg_data
);
  import plti_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  // wide enough for both the 8-bit register and the depth itself
  localparam int CW = ($clog2(TABLE_DEPTH + 1) > CFG_W) ? $clog2(TABLE_DEPTH + 1) : CFG_W;

  // ---------------------------------------------------------------
  // State
  // ---------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  cfg_r;
  logic [KEY_W-1:0]  key_r;
  logic [AW-1:0]     last_r;     // index of last active breakpoint
  logic [AW-1:0]     i_r;        // index of entry arriving on rdata in ST_SCAN
  entry_t            prev_r;     // lower breakpoint of segment under test
  entry_t            hi_r;       // upper breakpoint of matched segment
  logic [SEG_W-1:0]  seg_r;
  logic              neg_r;      // slope sign

  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_val_r, out_val_nxt;
  logic [SEG_W-1:0]  out_seg_r, out_seg_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  // ---------------------------------------------------------------
  // Table RAM: key and value of one breakpoint per word
  // ---------------------------------------------------------------
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  entry_t            ram_wdata, rdata;

  plti_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------
  // Divider for (|dt| * dx) / dp
  // ---------------------------------------------------------------
  div_req_t div_req;
  div_rsp_t div_rsp;

  plti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------
  logic              accept;
  logic              wr_in_range;
  logic [CW-1:0]     n_pts;
  logic              few_pts;
  logic [AW-1:0]     last_idx;
  logic              hit;
  logic [VAL_W:0]    dt;
  logic [VAL_W-1:0]  dt_mag;
  logic [KEY_W-1:0]  dx;
  logic [KEY_W-1:0]  dp;
  logic [VAL_W-1:0]  interp;
  logic [SEG_W-1:0]  seg_cur;

  assign accept      = start && !busy;
  assign wr_in_range = int'(in_entry_index) < TABLE_DEPTH;

  // points_in_use saturates at the table depth
  assign n_pts    = (int'(cfg_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(cfg_r);
  assign few_pts  = n_pts < CW'(2);
  assign last_idx = AW'(n_pts - CW'(1));

  // segment test: p[i-1] < x <= p[i], lowest match wins since scan runs upward
  assign hit     = (prev_r.key < key_r) && (key_r <= rdata.key);
  assign seg_cur = SEG_W'(i_r - AW'(1));

  // slope terms of the matched segment
  assign dt     = {1'b0, hi_r.value} - {1'b0, prev_r.value};
  assign dt_mag = dt[VAL_W] ? VAL_W'(-dt) : dt[VAL_W-1:0];
  assign dx     = key_r - prev_r.key;
  assign dp     = hi_r.key - prev_r.key;

  // quotient magnitude never exceeds |dt|, so the sum stays in range
  assign interp = neg_r ? (prev_r.value - div_rsp.quotient)
                        : (prev_r.value + div_rsp.quotient);

  // ---------------------------------------------------------------
  // FSM: next state
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_opcode == OP_QUERY && !few_pts) begin
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        // key at or below the first breakpoint finishes here
        if (key_r <= rdata.key) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_MUL;
        end else if (i_r == last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // FSM: outputs (RAM access, divider start, result register)
  // ---------------------------------------------------------------
  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = AW'(in_entry_index);
    ram_wdata.key    = in_key_value;
    ram_wdata.value  = in_table_value;
    ram_raddr        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = dt_mag * dx;
    div_req.divisor  = dp;
    out_valid_nxt    = 1'b0;
    out_val_nxt      = out_val_r;
    out_seg_nxt      = out_seg_r;
    out_stat_nxt     = out_stat_r;
    case (state_r)
      ST_IDLE: begin
        // entry 0 is read every idle cycle so it is ready in ST_FIRST
        ram_raddr = '0;
        if (accept) begin
          if (in_opcode == OP_WRITE) begin
            ram_we        = wr_in_range;
            out_valid_nxt = 1'b1;
            out_val_nxt   = '0;
            out_seg_nxt   = '0;
            out_stat_nxt  = STAT_WRITE;
          end else if (few_pts) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = '0;
            out_seg_nxt   = '0;
            out_stat_nxt  = STAT_FEW;
          end
        end
      end
      ST_FIRST: begin
        ram_raddr = AW'(1);
        if (key_r <= rdata.key) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = rdata.value;
          out_seg_nxt   = '0;
          out_stat_nxt  = (key_r == rdata.key) ? STAT_OK : STAT_LOW;
        end
      end
      ST_SCAN: begin
        ram_raddr = i_r + AW'(1);
        if (!hit && i_r == last_r) begin
          // no segment matched: clamp to the last breakpoint
          out_valid_nxt = 1'b1;
          out_val_nxt   = rdata.value;
          out_seg_nxt   = seg_cur;
          out_stat_nxt  = STAT_HIGH;
        end
      end
      ST_MUL: begin
        div_req.start = 1'b1;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = interp;
          out_seg_nxt   = seg_r;
          out_stat_nxt  = STAT_OK;
        end
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_val_r  <= out_val_nxt;
    out_seg_r  <= out_seg_nxt;
    out_stat_r <= out_stat_nxt;
    if (accept) begin
      key_r  <= in_key_value;
      last_r <= last_idx;
    end
    if (state_r == ST_FIRST) begin
      prev_r <= rdata;
      i_r    <= AW'(1);
    end
    if (state_r == ST_SCAN) begin
      if (hit) begin
        hi_r  <= rdata;
        seg_r <= seg_cur;
      end else begin
        prev_r <= rdata;
        i_r    <= i_r + AW'(1);
      end
    end
    if (state_r == ST_MUL) begin
      neg_r <= dt[VAL_W];
    end
  end

  assign busy              = (state_r != ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_result_value  = out_val_r;
  assign out_segment_index = out_seg_r;
  assign out_status        = out_stat_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `PLTI_ASSERT_NEXT(a_write_result, clk, rst_n,
    accept && in_opcode == OP_WRITE,
    out_valid && out_status == STAT_WRITE && !busy,
    "write transaction did not return write-done next cycle")

  `PLTI_ASSERT_NEXT(a_few_result, clk, rst_n,
    accept && in_opcode == OP_QUERY && few_pts,
    out_valid && out_status == STAT_FEW && out_result_value == '0,
    "too-few-points query did not return error next cycle")

  `PLTI_ASSERT_NOW(a_div_done_state, clk, rst_n,
    div_rsp.done,
    state_r == ST_DIV,
    "divider finished outside the divide state")

  `PLTI_ASSERT_NOW(a_search_result_busy, clk, rst_n,
    out_valid && out_status != STAT_WRITE && out_status != STAT_FEW,
    $past(busy),
    "search result issued without a query in progress")

endmodule
`default_nettype wire

// ===== dv/piecewise_linear_table_interpolator_checker.sv =====
// Checker for the table interpolator: predicts every transaction and compares results
module piecewise_linear_table_interpolator_checker #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_opcode,
  input  logic [plti_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [plti_pkg::KEY_W-1:0]    in_key_value,
  input  logic [plti_pkg::VAL_W-1:0]    in_table_value,
  input  logic                          out_valid,
  input  logic [plti_pkg::VAL_W-1:0]    out_result_value,
  input  logic [plti_pkg::SEG_W-1:0]    out_segment_index,
  input  logic [plti_pkg::STAT_W-1:0]   out_status,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [plti_pkg::CFG_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            outstanding,
  output int                            checked_count
);
  import plti_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [SEG_W-1:0] seg;
    status_t          status;
  } answer_t;

  logic [KEY_W-1:0] bp_key [TABLE_DEPTH];
  logic [VAL_W-1:0] bp_val [TABLE_DEPTH];
  logic [CFG_W-1:0] points_q;
  answer_t          answers_due [$];

  initial begin
    fail_count    = 0;
    checked_count = 0;
    outstanding   = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // Writes update the shadow table; queries clamp, scan for the lowest
  // segment with p[i] < key <= p[i+1], and interpolate with truncation to zero.
  function automatic answer_t predict_answer(input logic op, input logic [IDX_W-1:0] idx,
                                             input logic [KEY_W-1:0] key,
                                             input logic [VAL_W-1:0] tv);
    answer_t a;
    int      n;
    bit      found;
    longint  dt;
    longint  dx;
    longint  dp;
    a.value  = '0;
    a.seg    = '0;
    a.status = STAT_OK;
    found    = 1'b0;
    n = (int'(points_q) > TABLE_DEPTH) ? TABLE_DEPTH : int'(points_q);
    if (op == OP_WRITE) begin
      bp_key[idx] = key;
      bp_val[idx] = tv;
      a.status    = STAT_WRITE;
    end else if (n < 2) begin
      a.status = STAT_FEW;
    end else if (key < bp_key[0]) begin
      a.value  = bp_val[0];
      a.status = STAT_LOW;
    end else if (key == bp_key[0]) begin
      a.value = bp_val[0];
    end else begin
      for (int i = 0; i + 1 < n && !found; i++) begin
        if (bp_key[i] < key && key <= bp_key[i+1]) begin
          dt      = longint'(bp_val[i+1]) - longint'(bp_val[i]);
          dx      = longint'(key) - longint'(bp_key[i]);
          dp      = longint'(bp_key[i+1]) - longint'(bp_key[i]);
          a.value = VAL_W'(longint'(bp_val[i]) + (dt * dx) / dp);
          a.seg   = SEG_W'(i);
          found   = 1'b1;
        end
      end
      if (!found) begin
        a.value  = bp_val[n-1];
        a.seg    = SEG_W'(n - 2);
        a.status = STAT_HIGH;
      end
    end
    return a;
  endfunction

  // Results are matched before new transactions are queued.
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      answers_due.delete();
      points_q = '0;
      outstanding <= 0;
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result with none pending", out_result_value, 0);
        end else begin
          want = answers_due.pop_front();
          if (out_result_value !== want.value)
            report_mismatch("result_value", out_result_value, want.value);
          if (out_segment_index !== want.seg)
            report_mismatch("segment_index", out_segment_index, want.seg);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          checked_count++;
        end
      end
      if (cfg_valid && cfg_ready) points_q = cfg_data;
      if (start && !busy)
        answers_due.push_back(predict_answer(in_opcode, in_entry_index, in_key_value,
                                             in_table_value));
      outstanding <= answers_due.size();
    end
  end

endmodule

// ===== dv/tb_piecewise_linear_table_interpolator_core.sv =====
// Testbench top: stimulus and verdict for the table interpolator core
module tb_piecewise_linear_table_interpolator_core;
  import plti_pkg::*;

  localparam int TABLE_DEPTH  = 128;
  localparam int RANDOM_ITEMS = 550;
  localparam int CALM_TAIL    = 80;   // no idle bursts in the last transactions

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic                in_opcode      = OP_QUERY;
  logic [IDX_W-1:0]    in_entry_index = '0;
  logic [KEY_W-1:0]    in_key_value   = '0;
  logic [VAL_W-1:0]    in_table_value = '0;
  logic                cfg_valid      = 1'b0;
  logic [CFG_W-1:0]    cfg_data       = '0;
  logic                busy;
  logic                out_valid;
  logic [VAL_W-1:0]    out_result_value;
  logic [SEG_W-1:0]    out_segment_index;
  logic [STAT_W-1:0]   out_status;
  logic                cfg_ready;

  int fail_count;
  int outstanding;
  int checked_count;

  // Keys written so far, and the length of the written prefix of the table:
  // queries never search past that prefix.
  logic [KEY_W-1:0] key_copy [TABLE_DEPTH];
  bit               written  [TABLE_DEPTH];
  int               loaded         = 0;
  int               sent           = 0;
  int               writes_sent    = 0;
  int               queries_sent   = 0;
  int               settings_used  = 0;
  int               item_goal      = 0;
  bit               idle_stretch   = 1'b0;

  piecewise_linear_table_interpolator_core #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_key_value      (in_key_value),
    .in_table_value    (in_table_value),
    .out_valid         (out_valid),
    .out_result_value  (out_result_value),
    .out_segment_index (out_segment_index),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  piecewise_linear_table_interpolator_checker #(.TABLE_DEPTH(TABLE_DEPTH)) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_key_value      (in_key_value),
    .in_table_value    (in_table_value),
    .out_valid         (out_valid),
    .out_result_value  (out_result_value),
    .out_segment_index (out_segment_index),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .outstanding       (outstanding),
    .checked_count     (checked_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop, several times the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // One transaction; returns at the edge that accepts it, with start still high.
  // Idle bursts come in stretches and stop for the tail of the run.
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] tv);
    int gap;
    if (sent % 32 == 0) idle_stretch = $urandom_range(0, 1);
    gap = 0;
    if (idle_stretch && (item_goal == 0 || sent < item_goal - CALM_TAIL) &&
        $urandom_range(0, 2) == 0)
      gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_key_value   <= key;
    in_table_value <= tv;
    do @(posedge clk); while (busy);
    if (op == OP_WRITE) begin
      written[idx]  = 1'b1;
      key_copy[idx] = key;
      while (loaded < TABLE_DEPTH && written[loaded]) loaded++;
      writes_sent++;
    end else begin
      queries_sent++;
    end
    sent++;
  endtask

  // Hold off until every result is back and the core is idle
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic set_points(input int points);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(points);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Load entries 0..count-1: strictly increasing keys, or random keys when scrambled
  task automatic load_ramp(input int count, input bit scrambled);
    int               span;
    logic [KEY_W-1:0] k;
    k    = ($urandom_range(0, 3) == 0) ? '0 : KEY_W'($urandom_range(0, 16'h2000));
    span = (16'hFFFF - int'(k)) / count;
    if ($urandom_range(0, 4) == 0 && span > 3) span = 3;  // steep, narrow segments
    for (int e = 0; e < count; e++) begin
      send_item(OP_WRITE, IDX_W'(e), scrambled ? KEY_W'($urandom) : k, VAL_W'($urandom));
      k = k + KEY_W'($urandom_range(1, span));
    end
  endtask

  initial begin
    int               phase;
    int               pick;
    int               points;
    int               m;
    int               nq;
    int               seg;
    int               kind;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, a small steam-style table, clamps, exact hits,
    // a falling segment and a table that is not increasing.
    send_item(OP_QUERY, '0, 16'h1234, 16'hFFFF);         // no points set yet
    send_item(OP_WRITE, 7'd0,   16'h0320, 16'h20E1);     // 50.0   -> 32.88
    send_item(OP_WRITE, 7'd1,   16'h04F0, 16'h2C00);     // 79.0
    send_item(OP_WRITE, 7'd2,   16'h0800, 16'h5000);
    send_item(OP_WRITE, 7'd3,   16'h8660, 16'h7A8A);     // 2150.0 -> 122.54
    send_item(OP_WRITE, 7'd4,   16'hFFF0, 16'h1000);     // falling last segment
    send_item(OP_WRITE, 7'd127, 16'hFFFF, 16'hFFFF);
    set_points(1);
    send_item(OP_QUERY, '0, 16'h0400, 16'h0000);         // one point is too few
    set_points(5);
    send_item(OP_QUERY, '0, 16'h0000, 16'h0000);         // below first breakpoint
    send_item(OP_QUERY, '0, 16'h0320, 16'h0000);         // equal to first breakpoint
    send_item(OP_QUERY, '0, 16'h0400, 16'h0000);
    send_item(OP_QUERY, '0, 16'h04F0, 16'h0000);         // upper end of a segment
    send_item(OP_QUERY, '0, 16'h8000, 16'h0000);
    send_item(OP_QUERY, '0, 16'hFFE0, 16'h0000);         // negative slope, truncation
    send_item(OP_QUERY, '0, 16'hFFF0, 16'h0000);
    send_item(OP_QUERY, '0, 16'hFFFF, 16'hFFFF);         // above last breakpoint
    send_item(OP_WRITE, 7'd2, 16'h0300, 16'h0100);       // table no longer increasing
    send_item(OP_QUERY, '0, 16'h0400, 16'h0000);         // two segments match, lowest wins
    send_item(OP_QUERY, '0, 16'h0310, 16'h0000);
    set_points(3);
    send_item(OP_QUERY, '0, 16'h0600, 16'h0000);         // falls in no segment

    // Random phases: mostly small increasing tables with queries aimed at
    // segments, breakpoints and both clamps; some scrambled tables and stray writes.
    item_goal = sent + RANDOM_ITEMS;
    phase     = 0;
    while (sent < item_goal) begin
      pick = (phase < 3) ? ((phase == 1) ? 1 : 0) : $urandom_range(0, 19);
      if (pick == 0) begin
        if (loaded < TABLE_DEPTH) load_ramp(TABLE_DEPTH, 1'b0);
        if (phase == 0)       points = 255;
        else if (phase == 2)  points = 128;
        else                  points = $urandom_range(100, 255);
      end else if (pick == 1) begin
        points = (phase == 1) ? 0 : $urandom_range(0, 1);
      end else begin
        points = $urandom_range(2, 12);
        load_ramp(points, $urandom_range(0, 5) == 0);
      end
      set_points(points);
      m  = (points > TABLE_DEPTH) ? TABLE_DEPTH : points;
      nq = $urandom_range(8, 30);
      for (int q = 0; q < nq && sent < item_goal; q++) begin
        if ($urandom_range(0, 24) == 0) drain();
        kind = (m < 2) ? 4 : $urandom_range(0, 9);
        if (kind == 0) begin
          send_item(OP_WRITE, IDX_W'($urandom), KEY_W'($urandom), VAL_W'($urandom));
        end else begin
          seg = (m < 2) ? 0 : $urandom_range(0, m - 2);
          lo  = key_copy[seg];
          hi  = key_copy[seg + 1];
          case (kind)
            1:       key = key_copy[$urandom_range(0, m - 1)];
            2:       key = KEY_W'($urandom_range(0, int'(key_copy[0])));
            3:       key = KEY_W'($urandom_range(int'(key_copy[m - 1]), 16'hFFFF));
            4:       key = KEY_W'($urandom);
            default: key = (lo < hi) ? KEY_W'($urandom_range(int'(lo) + 1, int'(hi)))
                                     : KEY_W'($urandom);
          endcase
          send_item(OP_QUERY, IDX_W'($urandom), key, VAL_W'($urandom));
        end
      end
      phase++;
    end

    start <= 1'b0;
    for (int w = 0; w < 20000 && outstanding != 0; w++) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d transactions: %0d table writes, %0d queries, %0d point-count settings.",
             sent, writes_sent, queries_sent, settings_used);
    $display("Compared %0d results over empty, small, full and scrambled tables.",
             checked_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/plti_pkg.sv
rtl/core/plti_ram.sv
rtl/core/plti_div.sv
rtl/core/piecewise_linear_table_interpolator_core.sv
dv/piecewise_linear_table_interpolator_checker.sv
dv/tb_piecewise_linear_table_interpolator_core.sv
